>>> hw/rtl/swtm_pkg.sv
// Shared constants, codes and types for the sliding-window throughput meter.
`default_nettype none
package swtm_pkg;

    localparam int RING_DEPTH = 32;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int WIN_W      = 6;
    localparam int IVL_W      = 16;
    localparam int TIME_W     = 32;
    localparam int ACC_W      = 64;

    // Configuration register indexes
    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_WINDOW   = 1'b1;

    typedef enum logic [2:0] {
        MODE_REPORT  = 3'd0,
        MODE_TICK    = 3'd1,
        MODE_START   = 3'd2,
        MODE_STOP    = 3'd3,
        MODE_RESTART = 3'd4,
        MODE_QUERY   = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_INVALID      = 2'd1,
        STAT_TICK_STOPPED = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_IVL,
        S_DIV_WIN,
        S_ROLL,
        S_ACT,
        S_SUM,
        S_OUT
    } state_t;

    // Broadcast control from the sequencer to every bucket cell
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [ACC_W-1:0]  wr_size;
        logic [ACC_W-1:0]  wr_count;
        logic              clr_all;
        logic              clr_win;
        logic [CNT_W-1:0]  win;
        logic [CNT_W-1:0]  filled;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> hw/rtl/sliding_window_throughput_meter.sv
// Top level of the sliding-window throughput meter: sequencer, divider and bucket chain.
//
// Usage: present mode, now_sec, size and auto_start with start high while busy
// is low; that edge accepts the transaction. One result comes back per
// transaction, shown for exactly one cycle with done high; the receiver cannot
// stall it, so capture it on that edge. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle (index 0 interval_seconds,
// index 1 window_buckets).
// After the accepting edge, a stopped meter that stays stopped runs the
// action state and then the output state; one that starts also runs the
// 32-cell chain in between. A running meter first divides the elapsed time
// by the interval in a bit-serial divider, then files one bucket per cycle
// (up to 32), then runs the action, the window sum through the chain and
// the output state. A gap longer than the window replaces the rolls by a
// second divide. A stop skips the chain.
// The next transaction may be accepted at the edge that takes the result.
// Reset clears the meter to stopped, all totals zero, interval 1 and window
// 32; the next transaction may be accepted at the first edge after reset.
`default_nettype none
module sliding_window_throughput_meter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [31:0] now_sec,
    input  wire logic [31:0] size,
    input  wire logic        auto_start,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    output logic             done,
    output logic [1:0]       status,
    output logic             running,
    output logic [63:0]      window_size,
    output logic [63:0]      window_count,
    output logic [63:0]      cum_size,
    output logic [63:0]      cum_count,
    output logic [31:0]      run_seconds,
    output logic [5:0]       filled_count
);
    import swtm_pkg::*;

    localparam int SUM_W = $clog2(RING_DEPTH + 1);

    state_t state_reg, state_next;

    logic [IVL_W-1:0]  ivl_reg;
    logic [WIN_W-1:0]  win_cfg_reg;
    logic [CNT_W-1:0]  win_eff;
    logic [IVL_W-1:0]  ivl_eff;

    logic [2:0]        mode_reg;
    logic [TIME_W-1:0] now_reg;
    logic [31:0]       size_reg;
    logic              auto_reg;

    logic [ACC_W-1:0]  open_size_reg, open_count_reg;
    logic [ACC_W-1:0]  sum_size_reg, sum_count_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  filled_reg;
    logic [TIME_W-1:0] start_t_reg, stop_t_reg, last_t_reg;
    logic              run_reg;
    logic [CNT_W-1:0]  roll_cnt_reg;
    logic [SUM_W-1:0]  sum_cnt_reg;
    logic [1:0]        stat_reg;

    logic              done_reg;
    logic [1:0]        o_status_reg;
    logic              o_run_reg;
    logic [63:0]       o_wsize_reg, o_wcount_reg, o_tsize_reg, o_tcount_reg;
    logic [31:0]       o_runs_reg;
    logic [5:0]        o_fill_reg;

    logic              accept;
    logic              div_go;
    logic [TIME_W-1:0] div_dividend;
    logic [IVL_W-1:0]  div_divisor;
    logic              div_done;
    logic [TIME_W-1:0] div_quot;
    logic [IVL_W-1:0]  div_rem;

    logic [SLOT_W-1:0] slot_cur;
    logic [CNT_W:0]    slot_inc;
    logic [CNT_W:0]    slot_gap;
    logic              k_big;
    logic              do_start, do_add, do_stop;
    logic [1:0]        act_stat;
    cell_ctrl_t        ctrl;

    logic [ACC_W-1:0]  psize  [RING_DEPTH+1];
    logic [ACC_W-1:0]  pcount [RING_DEPTH+1];

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    // Effective interval and window
    assign ivl_eff = (ivl_reg == '0) ? IVL_W'(1) : ivl_reg;
    always_comb
    begin
        if (win_cfg_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (win_cfg_reg > WIN_W'(RING_DEPTH))
        begin
            win_eff = CNT_W'(RING_DEPTH);
        end
        else
        begin
            win_eff = CNT_W'(win_cfg_reg);
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ivl_reg     <= IVL_W'(1);
            win_cfg_reg <= WIN_W'(RING_DEPTH);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL: ivl_reg     <= cfg_data;
                CFG_WINDOW:   win_cfg_reg <= cfg_data[WIN_W-1:0];
                default:      ivl_reg     <= ivl_reg;
            endcase
        end
    end

    // Write slot, wrapped into the window
    assign slot_cur = (CNT_W'(slot_reg) >= win_eff) ? '0 : slot_reg;
    assign slot_inc = (CNT_W+1)'(slot_cur) + 1'b1;
    assign slot_gap = (CNT_W+1)'(slot_cur) + (CNT_W+1)'(div_rem[CNT_W-1:0]);
    assign k_big    = div_quot > TIME_W'(win_eff);

    // Decode the mode action
    always_comb
    begin
        do_start = 1'b0;
        do_add   = 1'b0;
        do_stop  = 1'b0;
        act_stat = STAT_OK;
        case (mode_reg)
            MODE_REPORT:
            begin
                if (run_reg)
                begin
                    do_add = 1'b1;
                end
                else if (auto_reg)
                begin
                    do_start = 1'b1;
                    do_add   = 1'b1;
                end
                else
                begin
                    act_stat = STAT_INVALID;
                end
            end
            MODE_TICK:
            begin
                if (!run_reg)
                begin
                    act_stat = STAT_TICK_STOPPED;
                end
            end
            MODE_START:
            begin
                if (run_reg)
                begin
                    act_stat = STAT_INVALID;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
            MODE_STOP:    do_stop  = run_reg;
            MODE_RESTART: do_start = 1'b1;
            default:      do_stop  = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = run_reg ? S_DIV_IVL : S_ACT;
                end
            end
            S_DIV_IVL:
            begin
                if (div_done)
                begin
                    if (div_quot == '0)
                    begin
                        state_next = S_ACT;
                    end
                    else if (k_big)
                    begin
                        state_next = S_DIV_WIN;
                    end
                    else
                    begin
                        state_next = S_ROLL;
                    end
                end
            end
            S_DIV_WIN:
            begin
                if (div_done)
                begin
                    state_next = S_ACT;
                end
            end
            S_ROLL:
            begin
                if (roll_cnt_reg == CNT_W'(1))
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = (do_start || (run_reg && !do_stop)) ? S_SUM : S_OUT;
            end
            S_SUM:
            begin
                if (sum_cnt_reg == SUM_W'(RING_DEPTH - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Divider and bucket-chain control
    always_comb
    begin
        div_go       = 1'b0;
        div_dividend = now_sec - last_t_reg;
        div_divisor  = ivl_eff;
        ctrl         = '0;
        ctrl.win     = win_eff;
        ctrl.filled  = filled_reg;
        ctrl.wr_slot = slot_cur;
        ctrl.wr_size = open_size_reg;
        ctrl.wr_count = open_count_reg;
        case (state_reg)
            S_IDLE:
            begin
                div_go = accept && run_reg;
            end
            S_DIV_IVL:
            begin
                div_go       = div_done && k_big;
                div_dividend = div_quot;
                div_divisor  = IVL_W'(win_eff);
            end
            S_DIV_WIN:
            begin
                div_divisor  = IVL_W'(win_eff);
                ctrl.clr_win = div_done;
            end
            S_ROLL:
            begin
                ctrl.wr_en = 1'b1;
            end
            S_ACT:
            begin
                ctrl.clr_all = do_start;
            end
            default:
            begin
                div_go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Meter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_size_reg  <= '0;
            open_count_reg <= '0;
            sum_size_reg   <= '0;
            sum_count_reg  <= '0;
            slot_reg       <= '0;
            filled_reg     <= '0;
            start_t_reg    <= '0;
            stop_t_reg     <= '0;
            last_t_reg     <= '0;
            run_reg        <= 1'b0;
            roll_cnt_reg   <= '0;
            sum_cnt_reg    <= '0;
            stat_reg       <= STAT_OK;
        end
        else
        begin
            case (state_reg)
                S_DIV_IVL:
                begin
                    if (div_done && (div_quot != '0))
                    begin
                        last_t_reg   <= now_reg - TIME_W'(div_rem);
                        roll_cnt_reg <= div_quot[CNT_W-1:0];
                    end
                end
                S_DIV_WIN:
                begin
                    if (div_done)
                    begin
                        slot_reg       <= (slot_gap >= (CNT_W+1)'(win_eff))
                                          ? SLOT_W'(slot_gap - (CNT_W+1)'(win_eff))
                                          : SLOT_W'(slot_gap);
                        filled_reg     <= win_eff;
                        open_size_reg  <= '0;
                        open_count_reg <= '0;
                    end
                end
                S_ROLL:
                begin
                    slot_reg       <= (slot_inc >= (CNT_W+1)'(win_eff))
                                      ? '0 : SLOT_W'(slot_inc);
                    filled_reg     <= (filled_reg < win_eff) ? filled_reg + 1'b1 : win_eff;
                    open_size_reg  <= '0;
                    open_count_reg <= '0;
                    roll_cnt_reg   <= roll_cnt_reg - 1'b1;
                end
                S_ACT:
                begin
                    stat_reg    <= act_stat;
                    sum_cnt_reg <= '0;
                    if (do_start)
                    begin
                        open_size_reg  <= do_add ? ACC_W'(size_reg) : '0;
                        open_count_reg <= do_add ? ACC_W'(1) : '0;
                        sum_size_reg   <= do_add ? ACC_W'(size_reg) : '0;
                        sum_count_reg  <= do_add ? ACC_W'(1) : '0;
                        slot_reg       <= '0;
                        filled_reg     <= '0;
                        start_t_reg    <= now_reg;
                        stop_t_reg     <= '0;
                        last_t_reg     <= now_reg;
                        run_reg        <= 1'b1;
                    end
                    else
                    begin
                        if (do_add)
                        begin
                            open_size_reg  <= open_size_reg + ACC_W'(size_reg);
                            open_count_reg <= open_count_reg + 1'b1;
                            sum_size_reg   <= sum_size_reg + ACC_W'(size_reg);
                            sum_count_reg  <= sum_count_reg + 1'b1;
                        end
                        if (do_stop)
                        begin
                            run_reg    <= 1'b0;
                            stop_t_reg <= now_reg;
                        end
                    end
                end
                S_SUM:
                begin
                    sum_cnt_reg <= sum_cnt_reg + 1'b1;
                end
                default:
                begin
                    stat_reg <= stat_reg;
                end
            endcase
        end
    end

    // Latch the transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= mode;
            now_reg  <= now_sec;
            size_reg <= size;
            auto_reg <= auto_start;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_OUT);
        end
    end

    // Hold the result fields
    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT)
        begin
            o_status_reg <= stat_reg;
            o_run_reg    <= run_reg;
            o_tsize_reg  <= sum_size_reg;
            o_tcount_reg <= sum_count_reg;
            if (run_reg)
            begin
                o_wsize_reg  <= psize[RING_DEPTH];
                o_wcount_reg <= pcount[RING_DEPTH];
                o_runs_reg   <= now_reg - start_t_reg;
                o_fill_reg   <= 6'(filled_reg);
            end
            else
            begin
                o_wsize_reg  <= sum_size_reg;
                o_wcount_reg <= sum_count_reg;
                o_runs_reg   <= (stop_t_reg != '0) ? stop_t_reg - start_t_reg : '0;
                o_fill_reg   <= '0;
            end
        end
    end

    swtm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Bucket chain; partial sums ripple from cell 0 to the last cell
    assign psize[0]  = '0;
    assign pcount[0] = '0;

    for (genvar g = 0; g < RING_DEPTH; g++)
    begin : g_cell
        swtm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (SLOT_W'(g)),
            .ctrl       (ctrl),
            .psize_in   (psize[g]),
            .pcount_in  (pcount[g]),
            .psize_out  (psize[g+1]),
            .pcount_out (pcount[g+1])
        );
    end

    assign done         = done_reg;
    assign status       = o_status_reg;
    assign running      = o_run_reg;
    assign window_size  = o_wsize_reg;
    assign window_count = o_wcount_reg;
    assign cum_size     = o_tsize_reg;
    assign cum_count    = o_tcount_reg;
    assign run_seconds  = o_runs_reg;
    assign filled_count = o_fill_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_fill_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !running) |-> (filled_count == '0))
        else $error("filled count nonzero while stopped");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (filled_count <= 6'(RING_DEPTH)))
        else $error("filled count beyond ring size");

endmodule
`default_nettype wire

>>> hw/rtl/swtm_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module swtm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       go,
    input  wire logic [swtm_pkg::TIME_W-1:0] dividend,
    input  wire logic [swtm_pkg::IVL_W-1:0]  divisor,
    output logic                            done,
    output logic [swtm_pkg::TIME_W-1:0]     quot,
    output logic [swtm_pkg::IVL_W-1:0]      rem
);
    import swtm_pkg::*;

    localparam int STEP_W = $clog2(TIME_W + 1);

    logic [TIME_W-1:0] quo_reg, quo_next;
    logic [IVL_W-1:0]  rem_reg, rem_next;
    logic [IVL_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [IVL_W:0]    trial;
    logic [IVL_W:0]    diff;

    // One shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[TIME_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        done_next = 1'b0;
        if (go)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            step_next = STEP_W'(TIME_W);
        end
        else if (step_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[IVL_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[IVL_W-1:0];
                quo_next = {quo_reg[TIME_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (go)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

>>> hw/rtl/swtm_cell.sv
// One ring bucket: stored size and count, plus one stage of the window sum chain.
`default_nettype none
module swtm_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [swtm_pkg::SLOT_W-1:0] idx,
    input  wire swtm_pkg::cell_ctrl_t        ctrl,
    input  wire logic [swtm_pkg::ACC_W-1:0]  psize_in,
    input  wire logic [swtm_pkg::ACC_W-1:0]  pcount_in,
    output logic [swtm_pkg::ACC_W-1:0]       psize_out,
    output logic [swtm_pkg::ACC_W-1:0]       pcount_out
);
    import swtm_pkg::*;

    logic             valid_reg;
    logic [ACC_W-1:0] size_reg;
    logic [ACC_W-1:0] count_reg;
    logic [ACC_W-1:0] psize_reg;
    logic [ACC_W-1:0] pcount_reg;
    logic [CNT_W-1:0] idx_ext;
    logic             in_win;
    logic             in_fill;
    logic             hit;

    assign idx_ext = CNT_W'(idx);
    assign in_win  = idx_ext < ctrl.win;
    assign in_fill = valid_reg && (idx_ext < ctrl.filled);
    assign hit     = ctrl.wr_en && (ctrl.wr_slot == idx);

    // Drop the bucket on a clear, take it on a write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clr_all || (ctrl.clr_win && in_win))
        begin
            valid_reg <= 1'b0;
        end
        else if (hit)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            size_reg  <= ctrl.wr_size;
            count_reg <= ctrl.wr_count;
        end
    end

    // Advance the partial sums toward the next cell
    always_ff @(posedge clk)
    begin
        psize_reg  <= psize_in + (in_fill ? size_reg : '0);
        pcount_reg <= pcount_in + (in_fill ? count_reg : '0);
    end

    assign psize_out  = psize_reg;
    assign pcount_out = pcount_reg;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for the sliding-window throughput meter with a behavioral predictor.
`default_nettype none
module tb_top;
    import swtm_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        running;
        logic [63:0] window_size;
        logic [63:0] window_count;
        logic [63:0] cum_size;
        logic [63:0] cum_count;
        logic [31:0] run_seconds;
        logic [5:0]  filled_count;
    } meter_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  mode;
    logic [31:0] now_sec;
    logic [31:0] size;
    logic        auto_start;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        done;
    logic [1:0]  status;
    logic        running;
    logic [63:0] window_size;
    logic [63:0] window_count;
    logic [63:0] cum_size;
    logic [63:0] cum_count;
    logic [31:0] run_seconds;
    logic [5:0]  filled_count;

    sliding_window_throughput_meter i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .now_sec(now_sec), .size(size), .auto_start(auto_start),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .status(status), .running(running),
        .window_size(window_size), .window_count(window_count),
        .cum_size(cum_size), .cum_count(cum_count),
        .run_seconds(run_seconds), .filled_count(filled_count)
    );

    // Predictor state
    logic [63:0] ring_size [RING_DEPTH];
    logic [63:0] ring_count [RING_DEPTH];
    logic [63:0] open_sz, open_cnt, tot_sz, tot_cnt;
    int unsigned slot, filled;
    logic [31:0] t_start, t_stop, t_roll;
    logic        meter_on;
    logic [15:0] reg_interval;
    logic [5:0]  reg_window;

    meter_result_t expected_results[$];
    int          mismatches;
    bit          idle_on;
    logic [31:0] clock_now;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned eff_window();
        if (reg_window == 0) return 1;
        if (reg_window > RING_DEPTH) return RING_DEPTH;
        return reg_window;
    endfunction

    task automatic file_bucket(int unsigned wb);
        if (slot >= wb) slot = 0;
        ring_size[slot] = open_sz;
        ring_count[slot] = open_cnt;
        slot = (slot + 1 >= wb) ? 0 : slot + 1;
        filled = (filled < wb) ? filled + 1 : wb;
        open_sz = 0;
        open_cnt = 0;
    endtask

    task automatic advance_buckets(logic [31:0] now);
        logic [31:0] iv;
        logic [31:0] k;
        int unsigned wb;
        int unsigned n;
        iv = (reg_interval == 0) ? 32'd1 : {16'd0, reg_interval};
        wb = eff_window();
        k = (now - t_roll) / iv;
        if (k == 0) return;
        t_roll = t_roll + iv * k;
        n = k;
        if (k > wb)
        begin
            if (slot >= wb) slot = 0;
            slot = (slot + (k - wb) % wb) % wb;
            open_sz = 0;
            open_cnt = 0;
            n = wb;
        end
        for (int i = 0; i < n; i++) file_bucket(wb);
    endtask

    task automatic begin_run(logic [31:0] now);
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_size[i] = 0;
            ring_count[i] = 0;
        end
        open_sz = 0; open_cnt = 0; slot = 0; filled = 0;
        tot_sz = 0; tot_cnt = 0;
        t_start = now; t_stop = 0; t_roll = now;
        meter_on = 1'b1;
    endtask

    task automatic end_run(logic [31:0] now);
        if (meter_on)
        begin
            meter_on = 1'b0;
            t_stop = now;
        end
    endtask

    // Compute the result of one transaction and advance the predictor
    task automatic predict_meter(logic [2:0] md, logic [31:0] now, logic [31:0] sz,
                                 logic as);
        meter_result_t r;
        logic [1:0] st;
        st = STAT_OK;
        r = '0;
        if (meter_on) advance_buckets(now);
        case (md)
            MODE_REPORT:
            begin
                if (!meter_on)
                begin
                    if (as) begin_run(now);
                    else st = STAT_INVALID;
                end
                if (st == STAT_OK)
                begin
                    open_sz += sz; open_cnt += 1;
                    tot_sz += sz; tot_cnt += 1;
                end
            end
            MODE_TICK: if (!meter_on) st = STAT_TICK_STOPPED;
            MODE_START:
            begin
                if (meter_on) st = STAT_INVALID;
                else begin_run(now);
            end
            MODE_STOP: end_run(now);
            MODE_RESTART:
            begin
                end_run(now);
                begin_run(now);
            end
            default: ;
        endcase
        if (meter_on)
        begin
            for (int i = 0; i < filled && i < RING_DEPTH; i++)
            begin
                r.window_size += ring_size[i];
                r.window_count += ring_count[i];
            end
            r.run_seconds = now - t_start;
            r.filled_count = filled[5:0];
        end
        else
        begin
            r.window_size = tot_sz;
            r.window_count = tot_cnt;
            r.run_seconds = (t_stop != 0) ? t_stop - t_start : 32'd0;
        end
        r.status = st;
        r.running = meter_on;
        r.cum_size = tot_sz;
        r.cum_count = tot_cnt;
        expected_results.push_back(r);
    endtask

    // Send one transaction and predict its result once busy has dropped
    task automatic send_item(logic [2:0] md, logic [31:0] now, logic [31:0] sz, logic as);
        @(posedge clk);
        while (idle_on && $urandom_range(99) < 17) @(posedge clk);
        start <= 1'b1;
        mode <= md;
        now_sec <= now;
        size <= sz;
        auto_start <= as;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_meter(md, now, sz, as);
        start <= 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_INTERVAL) reg_interval = val;
        else reg_window = val[5:0];
    endtask

    // Wait until every result has arrived, then pad for the worst latency
    task automatic drain_results();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        meter_result_t got;
        meter_result_t exp_r;
        if (rst_n && done)
        begin
            got = '{status, running, window_size, window_count, cum_size,
                    cum_count, run_seconds, filled_count};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", exp_r, got);
                end
            end
        end
    end

    task automatic test_directed();
        send_item(MODE_TICK, 32'd5, 32'd0, 1'b0);
        send_item(MODE_REPORT, 32'd5, 32'hFFFF_FFFF, 1'b0);
        send_item(MODE_STOP, 32'd6, 32'd0, 1'b0);
        send_item(MODE_REPORT, 32'd10, 32'hFFFF_FFFF, 1'b1);
        send_item(MODE_REPORT, 32'd10, 32'hFFFF_FFFF, 1'b0);
        send_item(MODE_START, 32'd11, 32'd0, 1'b0);
        send_item(MODE_TICK, 32'd12, 32'd0, 1'b0);
        send_item(MODE_REPORT, 32'd13, 32'd7, 1'b0);
        send_item(MODE_QUERY, 32'd15, 32'd0, 1'b0);
        send_item(3'd6, 32'd16, 32'd0, 1'b0);
        send_item(3'd7, 32'd17, 32'd0, 1'b0);
        send_item(MODE_REPORT, 32'd200, 32'd3, 1'b0);
        send_item(MODE_TICK, 32'd100, 32'd0, 1'b0);
        send_item(MODE_RESTART, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_item(MODE_REPORT, 32'd0, 32'd1, 1'b0);
        send_item(MODE_STOP, 32'd2, 32'd0, 1'b0);
        send_item(MODE_STOP, 32'd3, 32'd0, 1'b0);
        send_item(MODE_RESTART, 32'd4, 32'd0, 1'b0);
        send_item(MODE_QUERY, 32'd0, 32'd0, 1'b0);
        drain_results();
    endtask

    // Shrink the window under a running meter to push slot and fill past it
    task automatic test_window_shrink();
        send_item(MODE_RESTART, 32'd1000, 32'd0, 1'b0);
        for (int i = 1; i <= 30; i++) send_item(MODE_REPORT, 32'd1000 + i, i, 1'b0);
        drain_results();
        write_reg(CFG_WINDOW, 16'd4);
        send_item(MODE_QUERY, 32'd1030, 32'd0, 1'b0);
        send_item(MODE_REPORT, 32'd1031, 32'd9, 1'b0);
        send_item(MODE_QUERY, 32'd1040, 32'd0, 1'b0);
        drain_results();
        write_reg(CFG_WINDOW, 16'd0);
        send_item(MODE_TICK, 32'd1042, 32'd0, 1'b0);
        drain_results();
        write_reg(CFG_WINDOW, 16'd63);
        send_item(MODE_TICK, 32'd1050, 32'd0, 1'b0);
        drain_results();
    endtask

    task automatic random_item();
        logic [2:0]  md;
        logic [31:0] step;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) md = MODE_REPORT;
        else if (pick < 70) md = MODE_TICK;
        else if (pick < 77) md = MODE_QUERY;
        else if (pick < 83) md = MODE_STOP;
        else if (pick < 89) md = MODE_START;
        else if (pick < 95) md = MODE_RESTART;
        else md = 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 80) step = $urandom_range(3);
        else if (pick < 95) step = $urandom_range(80);
        else step = $urandom;
        clock_now = clock_now + step;
        send_item(md, clock_now, ($urandom_range(3) == 0) ? $urandom : $urandom_range(255),
                  1'($urandom_range(1)));
    endtask

    task automatic test_random(int n, logic [15:0] ivl, logic [15:0] win);
        write_reg(CFG_INTERVAL, ivl);
        write_reg(CFG_WINDOW, win);
        for (int i = 0; i < n; i++) random_item();
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0; mode = '0; now_sec = '0; size = '0; auto_start = 1'b0;
        cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        mismatches = 0;
        idle_on = 1'b1;
        clock_now = 32'd0;
        reg_interval = 16'd1;
        reg_window = 6'd32;
        meter_on = 1'b0;
        open_sz = 0; open_cnt = 0; tot_sz = 0; tot_cnt = 0;
        slot = 0; filled = 0; t_start = 0; t_stop = 0; t_roll = 0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            ring_size[i] = 0;
            ring_count[i] = 0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_window_shrink();
        test_random(300, 16'd1, 16'd32);
        test_random(250, 16'd3, 16'd5);
        idle_on = 1'b0;
        test_random(200, 16'd2, 16'd1);
        idle_on = 1'b1;
        test_random(200, 16'd0, 16'd0);
        test_random(200, 16'hFFFF, 16'd17);
        test_random(250, 16'd7, 16'd32);
        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule
`default_nettype wire
